/* design/f2fp12_pkg.sv */
// Package: constants shared by the float32 to fp12 converter.
package f2fp12_pkg;
    localparam logic [15:0] SIGN_WORD = 16'hF800;
    localparam logic [15:0] NAN_CODE  = 16'h07E1;
    localparam logic [15:0] INF_CODE  = 16'h07E0;
    localparam logic [7:0]  EXP_MAX   = 8'd255;
    localparam logic [7:0]  EXP_OVF   = 8'd158;
    localparam logic [7:0]  EXP_TINY  = 8'd91;
    localparam logic [7:0]  EXP_NORM  = 8'd97;
    localparam logic [7:0]  EXP_BASE  = 8'd96;
    localparam logic [7:0]  SUB_SHIFT = 8'd115;
endpackage

/* design/float32_to_fp12_convert.sv */
// Top level: float32 to fp12 converter with input and output registers.
// One float32 word in, one fp12 word out, one word per cycle sustained while the output is not stalled.
// A word taken at the input is stored in the input register, and the
// conversion logic (compare, shift, round, add) sits between that register
// and the result register, which holds the converted word until it is taken.
// Each stage advances whenever the stage after it is empty or being
// drained, so back-to-back words flow without bubbles and a stalled output
// holds both stages. NaN gives 0x07E1, overflow gives signed infinity
// 0x07E0, and the sign is replicated into bits 15..11.
module float32_to_fp12_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_float_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_fp12_bits
);
    import f2fp12_pkg::*;

    logic        r_in_vld;
    logic [31:0] r_in_word;
    logic        r_out_vld;
    logic [15:0] r_out_word;
    logic [15:0] n_out_word;
    logic        out_adv;
    logic        in_adv;

    f2fp12_core u_core (
        .i_float_bits (r_in_word),
        .o_fp12_bits  (n_out_word)
    );

    // advance output stage when it is empty or being taken
    assign out_adv = !r_out_vld || i_ready;
    assign in_adv  = !r_in_vld || out_adv;
    assign o_ready = in_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_adv) r_in_vld <= i_valid;
            if (out_adv) r_out_vld <= r_in_vld;
        end
        if (in_adv && i_valid) r_in_word <= i_float_bits;
        if (out_adv && r_in_vld) r_out_word <= n_out_word;
    end

    assign o_valid     = r_out_vld;
    assign o_fp12_bits = r_out_word;
endmodule

/* design/f2fp12_core.sv */
// Combinational conversion of one float32 word to an fp12 word.
module f2fp12_core (
    input  logic [31:0] i_float_bits,
    output logic [15:0] o_fp12_bits
);
    import f2fp12_pkg::*;

    logic [15:0] sign;
    logic [7:0]  bexp;
    logic [22:0] mant;
    logic [23:0] sig;
    logic [4:0]  sh;
    logic [5:0]  q_sub;
    logic [23:0] rem_sub;
    logic [23:0] half_sub;
    logic [23:0] mask_sub;
    logic [5:0]  q_sub_r;
    logic [5:0]  q_nrm;
    logic [5:0]  ef;
    logic [15:0] nrm_word;

    always_comb begin
        sign = i_float_bits[31] ? SIGN_WORD : 16'h0000;
        bexp = i_float_bits[30:23];
        mant = i_float_bits[22:0];
        sig  = {1'b1, mant};
        // shift is 19..24 in the subnormal band
        sh       = 5'(SUB_SHIFT - bexp);
        q_sub    = 6'(sig >> sh);
        mask_sub = (24'd1 << sh) - 24'd1;
        rem_sub  = sig & mask_sub;
        half_sub = 24'd1 << (sh - 5'd1);
        q_sub_r  = q_sub + 6'((rem_sub > half_sub) ||
                   ((rem_sub == half_sub) && q_sub[0]));
        // normal band: round mantissa to 5 bits, carry may bump exponent
        q_nrm = {1'b0, mant[22:18]} + 6'(mant[17] &&
                ((mant[16:0] != 17'd0) || mant[18]));
        ef       = 6'(bexp - EXP_BASE);
        nrm_word = {5'd0, ef, 5'd0} + {10'd0, q_nrm};

        if (bexp == EXP_MAX && mant != 23'd0) begin
            o_fp12_bits = sign | NAN_CODE;
        end else if (bexp > EXP_OVF) begin
            o_fp12_bits = sign | INF_CODE;
        end else if (bexp < EXP_TINY) begin
            o_fp12_bits = sign;
        end else if (bexp < EXP_NORM) begin
            o_fp12_bits = sign | {10'd0, q_sub_r};
        end else begin
            o_fp12_bits = sign | nrm_word;
        end
    end
endmodule
